// ===== rtl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg: shared types, constants and step tables for the grid ray marcher
// Word layouts, controller states, and the sine/cosine step table built at
// elaboration: computed in Q30 fixed point, stored as signed 10-bit steps.
// ----------------------------------------------------------------------------
package grm_pkg;

  localparam int MAP_CELLS_DEF = 40;
  localparam int ANGLE_STEPS   = 360;
  localparam int QUAD          = 90;
  localparam int UNIT          = 65535;

  // input word fields
  localparam int CELL_IN_W = 6;
  localparam int VAL_W     = 8;
  localparam int ANG_W     = 9;
  localparam int IN_ROW_LSB  = 0;
  localparam int IN_COL_LSB  = 6;
  localparam int IN_VAL_LSB  = 12;
  localparam int IN_SX_LSB   = 20;
  localparam int IN_SY_LSB   = 26;
  localparam int IN_HEAD_LSB = 32;
  localparam int IN_OFF_LSB  = 41;
  localparam int IN_DATA_W   = 56;

  // result word fields
  localparam int DELTA_W  = 23;
  localparam int DIST_W   = 44;
  localparam int STEP_W   = 13;
  localparam int STEP_MAX = (1 << STEP_W) - 1;
  localparam int OUT_DX_LSB    = 0;
  localparam int OUT_DY_LSB    = 23;
  localparam int OUT_DIST_LSB  = 46;
  localparam int OUT_STEPS_LSB = 90;
  localparam int OUT_USED_W    = 103;
  localparam int OUT_DATA_W    = 104;

  // operation codes carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // march datapath
  localparam int COORD_W = 8;
  localparam int FRAC_W  = 16;
  localparam int TRIG_W  = 10;
  localparam int SUM_W   = FRAC_W + 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ANGLE,
    ST_LOAD,
    ST_MARCH,
    ST_SQX,
    ST_SQY,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_ent_t;

  typedef trig_ent_t [QUAD-1:0] trig_quad_t;
  typedef trig_quad_t [3:0]     trig_tab_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] c;
    logic [FRAC_W-1:0]         f;
  } axis_t;

  localparam longint QONE    = 64'sd1 <<< 30;
  localparam longint ROM_DIV = 64'sd1 <<< 37;
  localparam longint EPS_Q30 = 64'sd1425;

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) / QONE;
  endfunction

  function automatic trig_tab_t build_trig();
    trig_tab_t tab;
    longint phi, p2, ts, tc, ss, sc, sv, cv;
    for (int q = 0; q < 4; q++) begin
      for (int m = 0; m < QUAD; m++) begin
        phi = (longint'(m) * 64'sd314159 * QONE + 64'sd9000000) / 64'sd18000000
              - longint'(q) * EPS_Q30;
        p2 = qmul(phi, phi);
        ts = phi;
        tc = QONE;
        ss = phi;
        sc = QONE;
        ts = -qmul(ts, p2) / 6;   tc = -qmul(tc, p2) / 2;   ss += ts; sc += tc;
        ts = -qmul(ts, p2) / 20;  tc = -qmul(tc, p2) / 12;  ss += ts; sc += tc;
        ts = -qmul(ts, p2) / 42;  tc = -qmul(tc, p2) / 30;  ss += ts; sc += tc;
        ts = -qmul(ts, p2) / 72;  tc = -qmul(tc, p2) / 56;  ss += ts; sc += tc;
        ts = -qmul(ts, p2) / 110; tc = -qmul(tc, p2) / 90;  ss += ts; sc += tc;
        ts = -qmul(ts, p2) / 156; tc = -qmul(tc, p2) / 132; ss += ts; sc += tc;
        ts = -qmul(ts, p2) / 210; tc = -qmul(tc, p2) / 182; ss += ts; sc += tc;
        case (q)
          0: begin
            sv = ss;
            cv = sc;
          end
          1: begin
            sv = sc;
            cv = -ss;
          end
          2: begin
            sv = -ss;
            cv = -sc;
          end
          default: begin
            sv = -sc;
            cv = ss;
          end
        endcase
        tab[q][m].sin_v = TRIG_W'((sv * UNIT) / ROM_DIV);
        tab[q][m].cos_v = TRIG_W'((cv * UNIT) / ROM_DIV);
      end
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig();

  // advance one axis kept as cell index plus remainder in [0, UNIT)
  function automatic axis_t axis_step(input logic signed [COORD_W-1:0] c,
                                      input logic [FRAC_W-1:0] f,
                                      input logic signed [TRIG_W-1:0] s);
    axis_t r;
    logic signed [SUM_W-1:0] t;
    t = $signed({2'b00, f}) + SUM_W'(s);
    r.c = c;
    r.f = FRAC_W'(t);
    if (t >= SUM_W'(UNIT)) begin
      r.c = c + COORD_W'(1);
      r.f = FRAC_W'(t - SUM_W'(UNIT));
    end else if (t < 0) begin
      r.c = c - COORD_W'(1);
      r.f = FRAC_W'(t + SUM_W'(UNIT));
    end
    return r;
  endfunction

endpackage

// ===== rtl/grid_ray_march_top.sv =====
// ----------------------------------------------------------------------------
// grid_ray_march_top: fixed-step ray march over a map of wall flags
// Write words give no result. A cast passes the setup states ST_ANGLE and
// ST_LOAD, then takes up to ~7300 ray steps, one per cycle in ST_MARCH (one
// wall-map RAM read each; a wall is seen on the registered read and the
// position on it holds), then squares and emits via ST_SQX, ST_SQY, ST_EMIT.
// Reset clears the wall map one cell per cycle, all MAP_CELLS^2 cells (1600 by
// default), with in_tready low; the result register resets empty.
// ----------------------------------------------------------------------------
module grid_ray_march_top #(
  parameter int MAP_CELLS = grm_pkg::MAP_CELLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cell_row, cell_col, cell_value, start_x, start_y, heading, ray_offset
  input  logic [grm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,   // operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // delta_x, delta_y, distance_squared, step_count
  output logic [grm_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser   // hit_wall
);
  import grm_pkg::*;

  localparam int DEPTH = MAP_CELLS * MAP_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAP_CELLS);
  localparam int DW    = $clog2(MAP_CELLS * UNIT + (1 << TRIG_W)) + 1;
  localparam int PW    = 2 * DW;
  localparam logic signed [COORD_W-1:0] MAP_C = COORD_W'(MAP_CELLS);

  st_t st_r, st_nxt;

  // input word fields
  logic [CELL_IN_W-1:0] in_row, in_col, in_sx, in_sy;
  logic [VAL_W-1:0]     in_val;
  logic [ANG_W-1:0]     in_head;
  logic [ANG_W-1:0]     in_off;
  logic                 in_acc;

  assign in_row  = in_tdata[IN_ROW_LSB +: CELL_IN_W];
  assign in_col  = in_tdata[IN_COL_LSB +: CELL_IN_W];
  assign in_val  = in_tdata[IN_VAL_LSB +: VAL_W];
  assign in_sx   = in_tdata[IN_SX_LSB +: CELL_IN_W];
  assign in_sy   = in_tdata[IN_SY_LSB +: CELL_IN_W];
  assign in_head = in_tdata[IN_HEAD_LSB +: ANG_W];
  assign in_off  = in_tdata[IN_OFF_LSB +: ANG_W];
  assign in_acc  = in_tvalid && in_tready;

  // captured cast and march state
  logic [CELL_IN_W-1:0]      sx_r, sy_r;
  logic [ANG_W-1:0]          head_r;
  logic signed [ANG_W-1:0]   off_r;
  logic [ANG_W-1:0]          ang_r, ang_nxt;
  trig_ent_t                 trig_r, trig_sel;
  logic signed [COORD_W-1:0] cx_r, cy_r;
  logic [FRAC_W-1:0]         fx_r, fy_r;
  logic signed [DW-1:0]      dx_r, dy_r;
  logic [STEP_W-1:0]         steps_r;
  logic                      pend_r, pend_nxt;
  logic                      hit_r;
  logic [AW-1:0]             clr_r;
  logic [DIST_W-1:0]         sqx_r, sqy_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic                      out_user_r;

  // FSM outputs
  logic clr_en, emit_go;

  // wall map RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, wr_addr;
  logic          ram_wdata, rd_wall, wr_ok;

  assign wr_ok   = (in_row < MAP_CELLS) && (in_col < MAP_CELLS);
  assign wr_addr = AW'(in_row) * AW'(MAP_CELLS) + AW'(in_col);

  assign ram_we    = clr_en || (in_acc && (in_tuser == OP_WRITE) && wr_ok);
  assign ram_waddr = clr_en ? clr_r : wr_addr;
  assign ram_wdata = clr_en ? 1'b0 : (in_val != '0);

  grm_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (rd_wall)
  );

  // angle wrap: heading + offset + 360 lies in 104..1126
  logic signed [11:0] ang_sum;
  assign ang_sum = $signed({3'b000, head_r}) + 12'(off_r) + 12'sd360;

  always_comb begin
    if (ang_sum >= 12'sd1080) begin
      ang_nxt = ANG_W'(ang_sum - 12'sd1080);
    end else if (ang_sum >= 12'sd720) begin
      ang_nxt = ANG_W'(ang_sum - 12'sd720);
    end else if (ang_sum >= 12'sd360) begin
      ang_nxt = ANG_W'(ang_sum - 12'sd360);
    end else begin
      ang_nxt = ANG_W'(ang_sum);
    end
  end

  // quadrant split for the step table
  logic [1:0] quad;
  logic [6:0] mdeg;

  always_comb begin
    if (ang_r >= 9'd270) begin
      quad = 2'd3;
      mdeg = 7'(ang_r - 9'd270);
    end else if (ang_r >= 9'd180) begin
      quad = 2'd2;
      mdeg = 7'(ang_r - 9'd180);
    end else if (ang_r >= 9'd90) begin
      quad = 2'd1;
      mdeg = 7'(ang_r - 9'd90);
    end else begin
      quad = 2'd0;
      mdeg = 7'(ang_r);
    end
  end

  assign trig_sel = TRIG_TAB[quad][mdeg];

  // one ray step: x follows sine, y follows cosine
  axis_t                     ax_n, ay_n;
  logic signed [COORD_W-1:0] nx_c, ny_c;
  logic [FRAC_W-1:0]         nx_f, ny_f;
  logic                      nx_ok, wall_stop, stop;

  assign ax_n = axis_step(cx_r, fx_r, trig_r.sin_v);
  assign ay_n = axis_step(cy_r, fy_r, trig_r.cos_v);
  assign nx_c = ax_n.c;
  assign nx_f = ax_n.f;
  assign ny_c = ay_n.c;
  assign ny_f = ay_n.f;

  // position 0 and MAP_CELLS*UNIT count as outside
  assign nx_ok = (nx_c > 0 || (nx_c == 0 && nx_f != '0)) && (nx_c < MAP_C) &&
                 (ny_c > 0 || (ny_c == 0 && ny_f != '0)) && (ny_c < MAP_C);

  // read issued last cycle covers the current position
  assign wall_stop = pend_r && rd_wall;
  assign stop      = wall_stop || !nx_ok;
  assign ram_raddr = AW'(ny_c[CW-1:0]) * AW'(MAP_CELLS) + AW'(nx_c[CW-1:0]);

  // shared squarer
  logic signed [DW-1:0] mul_in;
  logic signed [PW-1:0] prod;
  assign mul_in = (st_r == ST_SQX) ? dx_r : dy_r;
  assign prod   = mul_in * mul_in;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && (in_tuser == OP_CAST)) st_nxt = ST_ANGLE;
      end
      ST_ANGLE: st_nxt = ST_LOAD;
      ST_LOAD:  st_nxt = ST_MARCH;
      ST_MARCH: begin
        if (stop) st_nxt = ST_SQX;
      end
      ST_SQX:   st_nxt = ST_SQY;
      ST_SQY:   st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) st_nxt = ST_IDLE;
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready = (st_r == ST_IDLE);
    clr_en    = (st_r == ST_CLEAR);
    emit_go   = (st_r == ST_EMIT) && (!out_valid_r || out_tready);
  end

  assign pend_nxt      = (st_r == ST_MARCH) && !stop;
  assign out_valid_nxt = emit_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_en) begin
        clr_r <= clr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sx_r   <= in_sx;
      sy_r   <= in_sy;
      head_r <= in_head;
      off_r  <= $signed(in_off);
    end
    if (st_r == ST_ANGLE) begin
      ang_r <= ang_nxt;
    end
    if (st_r == ST_LOAD) begin
      trig_r  <= trig_sel;
      cx_r    <= COORD_W'(sx_r);
      cy_r    <= COORD_W'(sy_r);
      fx_r    <= '0;
      fy_r    <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      steps_r <= '0;
    end
    if (st_r == ST_MARCH) begin
      // hold the position that sits on a wall, else advance
      if (!wall_stop) begin
        cx_r <= nx_c;
        fx_r <= nx_f;
        cy_r <= ny_c;
        fy_r <= ny_f;
        dx_r <= dx_r + DW'(trig_r.sin_v);
        dy_r <= dy_r + DW'(trig_r.cos_v);
        if (steps_r != STEP_W'(STEP_MAX)) begin
          steps_r <= steps_r + STEP_W'(1);
        end
      end
      if (stop) begin
        hit_r <= wall_stop;
      end
    end
    if (st_r == ST_SQX) begin
      sqx_r <= DIST_W'(prod);
    end
    if (st_r == ST_SQY) begin
      sqy_r <= DIST_W'(prod);
    end
    if (emit_go) begin
      out_data_r <= {{(OUT_DATA_W - OUT_USED_W){1'b0}}, steps_r, sqx_r + sqy_r,
                     DELTA_W'(dy_r), DELTA_W'(dx_r)};
      out_user_r <= hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/grm_ram.sv =====
// ----------------------------------------------------------------------------
// grm_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module grm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/grm_checker.sv =====
// ----------------------------------------------------------------------------
// grm_checker: port-level checks for the grid ray marcher
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module grm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [grm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import grm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a cast occupies the block, so no word is taken right behind it
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_CAST) |=> !in_tready)
    else $error("input taken right after a cast");

  // every cast takes at least one step
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_STEPS_LSB +: STEP_W] != '0)
    else $error("step count of zero");

  // a nonzero step vector never returns to the start
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DIST_LSB +: DIST_W] != '0)
    else $error("zero distance on a result word");

endmodule

bind grid_ray_march_top grm_checker u_grm_checker (.*);
